// ===== rtl/core/fbm_pkg.sv =====
// shared constants and types for the fractal value noise pipeline
// no dependencies
package fbm_pkg;

  // octave count as carried through the pipeline, holds 1..MAX_OCTAVES
  localparam int OCT_W = 5;

  // lattice hash multipliers
  localparam logic [31:0] HASH_KX  = 32'h8da6b343;
  localparam logic [31:0] HASH_KZ  = 32'hd8163841;
  localparam logic [31:0] HASH_KS  = 32'hcb1ab31f;
  localparam logic [31:0] HASH_MIX = 32'h5bd1e995;

  // seed increment between octaves
  localparam logic [31:0] SEED_STEP = 32'd101;

  // 0.03 in Q0.24, the fractional part of the 2.03 octave scale
  localparam logic [19:0] SCALE_FRAC = 20'd503316;

  // 3.0 in Q2.24 for the smoothstep fade
  localparam logic [25:0] FADE_THREE = 26'd50331648;

  // largest Q0.24 result
  localparam logic [23:0] Q24_MAX = 24'hffffff;

  // control that travels with each item
  typedef struct packed {
    logic             valid;
    logic [OCT_W-1:0] octaves;
  } fbm_ctl_t;

endpackage

// ===== rtl/core/fbm_in_if.sv =====
// input channel: one sample point per transfer
// no dependencies
interface fbm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_z;
  logic        [3:0]  octave_count;
  logic        [31:0] seed;

  modport source (output valid, pos_x, pos_z, octave_count, seed, input ready);
  modport sink   (input valid, pos_x, pos_z, octave_count, seed, output ready);
endinterface

// ===== rtl/core/fbm_out_if.sv =====
// output channel: one noise value per transfer
// no dependencies
interface fbm_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// ===== rtl/core/fbm_octave.sv =====
// one noise octave as a five stage pipeline: hash, fade, blend, accumulate,
// plus the position update for the next octave; depends on fbm_pkg
module fbm_octave import fbm_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_OCTAVES = 8,
  parameter int OCT_IDX     = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step_en,
  input  fbm_ctl_t                       ctl_in,
  input  logic signed [32+FRAC_BITS-1:0] px_in,
  input  logic signed [32+FRAC_BITS-1:0] pz_in,
  input  logic        [31:0]             seed_in,
  input  logic        [24+MAX_OCTAVES-1:0] acc_in,
  output fbm_ctl_t                       ctl_out,
  output logic signed [32+FRAC_BITS-1:0] px_out,
  output logic signed [32+FRAC_BITS-1:0] pz_out,
  output logic        [31:0]             seed_out,
  output logic        [24+MAX_OCTAVES-1:0] acc_out
);

  localparam int PW    = 32 + FRAC_BITS;
  localparam int ACC_W = 24 + MAX_OCTAVES;
  localparam int HW    = PW - 4;
  localparam longint OFF_X_L = ((longint'(173) <<< (FRAC_BITS + 1)) + 10) / 20;
  localparam longint OFF_Z_L = -(((longint'(91) <<< (FRAC_BITS + 1)) + 10) / 20);
  localparam logic signed [PW+1:0] OFF_X = (PW+2)'(OFF_X_L);
  localparam logic signed [PW+1:0] OFF_Z = (PW+2)'(OFF_Z_L);
  localparam logic [OCT_W-1:0] IDX = OCT_W'(OCT_IDX);

  // carried fields, one set per stage
  fbm_ctl_t           ctl1, ctl2, ctl3, ctl4;
  logic signed [PW-1:0] p1 [2];
  logic signed [PW-1:0] p2 [2];
  logic signed [PW-1:0] p3 [2];
  logic signed [PW-1:0] p4 [2];
  logic [31:0]        seed1, seed2, seed3, seed4;
  logic [ACC_W-1:0]   acc1, acc2, acc3, acc4;

  // stage 1: lattice products, fraction squares, scale products
  logic signed [PW-1:0] p_in [2];
  logic [31:0] lat [2];
  logic [23:0] t_in [2];
  logic [PW-1:0] mag [2];
  logic [31:0] hx1 [2];
  logic [31:0] hz1 [2];
  logic [31:0] hs1;
  logic [47:0] tt1 [2];
  logic [23:0] t1 [2];
  logic [43:0] mlo1 [2];
  logic [PW-5:0] mhi1 [2];
  logic neg1 [2];

  assign p_in[0] = px_in;
  assign p_in[1] = pz_in;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      lat[a]  = p_in[a][PW-1:FRAC_BITS];
      t_in[a] = 24'(p_in[a][FRAC_BITS-1:0]) << (24 - FRAC_BITS);
      mag[a]  = p_in[a][PW-1] ? PW'(-p_in[a]) : p_in[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else if (step_en) begin
      ctl1.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      ctl1.octaves <= ctl_in.octaves;
      seed1        <= seed_in;
      acc1         <= acc_in;
      hs1          <= seed_in * HASH_KS;
      hx1[0]       <= lat[0] * HASH_KX;
      hx1[1]       <= (lat[0] + 32'd1) * HASH_KX;
      hz1[0]       <= lat[1] * HASH_KZ;
      hz1[1]       <= (lat[1] + 32'd1) * HASH_KZ;
      for (int a = 0; a < 2; a++) begin
        p1[a]   <= p_in[a];
        t1[a]   <= t_in[a];
        tt1[a]  <= t_in[a] * t_in[a];
        mlo1[a] <= mag[a][23:0] * SCALE_FRAC;
        mhi1[a] <= HW'(mag[a][PW-1:24] * SCALE_FRAC);
        neg1[a] <= p_in[a][PW-1];
      end
    end
  end

  // stage 2: corner hash mix, fade product, signed 0.03 term
  logic [31:0] hpre [4];
  logic [31:0] hm2 [4];
  logic [49:0] fu2 [2];
  logic signed [PW-1:0] sx2 [2];
  logic [HW-1:0] q_c [2];
  logic [25:0] u_c [2];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hpre[c] = hx1[c % 2] ^ hz1[c / 2] ^ hs1;
      hpre[c] = hpre[c] ^ (hpre[c] >> 13);
    end
    for (int a = 0; a < 2; a++) begin
      q_c[a] = mhi1[a] + HW'(mlo1[a][43:24]);
      u_c[a] = FADE_THREE - {1'b0, t1[a], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else if (step_en) begin
      ctl2.valid <= ctl1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      ctl2.octaves <= ctl1.octaves;
      seed2        <= seed1;
      acc2         <= acc1;
      for (int c = 0; c < 4; c++) begin
        hm2[c] <= hpre[c] * HASH_MIX;
      end
      for (int a = 0; a < 2; a++) begin
        p2[a]  <= p1[a];
        fu2[a] <= tt1[a][47:24] * u_c[a];
        // floor of a negative product: -q - 1 when any bits were dropped
        sx2[a] <= neg1[a] ? ~PW'(q_c[a]) + PW'(mlo1[a][23:0] == 24'd0)
                          : PW'(q_c[a]);
      end
    end
  end

  // stage 3: corner values, first blend products, position update
  logic [31:0] hfin [4];
  logic [23:0] cv [4];
  logic signed [24:0] dx_ab, dx_cd;
  logic signed [26:0] wx_s;
  logic signed [PW+1:0] psum [2];
  logic signed [PW-1:0] pnew [2];
  logic signed [51:0] pab3, pcd3;
  logic [23:0] a3, c3;
  logic [25:0] wz3;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hfin[c] = hm2[c] ^ (hm2[c] >> 15);
      cv[c]   = hfin[c][23:0];
    end
    dx_ab = $signed({1'b0, cv[1]}) - $signed({1'b0, cv[0]});
    dx_cd = $signed({1'b0, cv[3]}) - $signed({1'b0, cv[2]});
    wx_s  = $signed({1'b0, fu2[0][49:24]});
    for (int a = 0; a < 2; a++) begin
      psum[a] = $signed({p2[a][PW-1], p2[a], 1'b0})
              + $signed({{2{sx2[a][PW-1]}}, sx2[a]})
              + ((a == 0) ? OFF_X : OFF_Z);
      // saturate to the signed position range
      if (psum[a][PW+1:PW-1] == 3'b000 || psum[a][PW+1:PW-1] == 3'b111) begin
        pnew[a] = psum[a][PW-1:0];
      end else if (psum[a][PW+1]) begin
        pnew[a] = {1'b1, {(PW-1){1'b0}}};
      end else begin
        pnew[a] = {1'b0, {(PW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else if (step_en) begin
      ctl3.valid <= ctl2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      ctl3.octaves <= ctl2.octaves;
      seed3        <= seed2;
      acc3         <= acc2;
      p3[0]        <= pnew[0];
      p3[1]        <= pnew[1];
      a3           <= cv[0];
      c3           <= cv[2];
      wz3          <= fu2[1][49:24];
      pab3         <= dx_ab * wx_s;
      pcd3         <= dx_cd * wx_s;
    end
  end

  // stage 4: finish x blends, product of the z blend
  logic signed [28:0] ab_s, cd_s;
  logic [23:0] ab_c, cd_c;
  logic signed [24:0] dz;
  logic signed [51:0] pz4;
  logic [23:0] ab4;

  always_comb begin
    ab_s = $signed({5'b0, a3}) + $signed({pab3[51], pab3[51:24]});
    cd_s = $signed({5'b0, c3}) + $signed({pcd3[51], pcd3[51:24]});
    ab_c = ab_s[23:0];
    cd_c = cd_s[23:0];
    dz   = $signed({1'b0, cd_c}) - $signed({1'b0, ab_c});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4.valid <= 1'b0;
    end else if (step_en) begin
      ctl4.valid <= ctl3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      ctl4.octaves <= ctl3.octaves;
      seed4        <= seed3;
      acc4         <= acc3;
      p4[0]        <= p3[0];
      p4[1]        <= p3[1];
      ab4          <= ab_c;
      pz4          <= dz * $signed({1'b0, wz3});
    end
  end

  // stage 5: octave value weighted by 2^(n-1-i) into the running sum
  logic signed [28:0] v_s;
  logic [23:0] v_c;
  logic [OCT_W-1:0] wsh;
  logic [ACC_W-1:0] acc_next;

  always_comb begin
    v_s = $signed({5'b0, ab4}) + $signed({pz4[51], pz4[51:24]});
    v_c = v_s[23:0];
    wsh = ctl4.octaves - IDX - OCT_W'(1);
    if (IDX < ctl4.octaves) begin
      acc_next = acc4 + (ACC_W'(v_c) << wsh);
    end else begin
      acc_next = acc4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (step_en) begin
      ctl_out.valid <= ctl4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      ctl_out.octaves <= ctl4.octaves;
      seed_out        <= seed4 + SEED_STEP;
      acc_out         <= acc_next;
      px_out          <= p4[0];
      pz_out          <= p4[1];
    end
  end

endmodule

// ===== rtl/core/fbm_div.sv =====
// pipelined restoring divider: sum / (2^n - 1), up to four quotient bits a stage
// depends on fbm_pkg
module fbm_div import fbm_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_en,
  input  fbm_ctl_t                    ctl_in,
  input  logic [24+MAX_OCTAVES-1:0]   acc_in,
  output logic                        quot_valid,
  output logic [24+MAX_OCTAVES-1:0]   quot
);

  localparam int ACC_W = 24 + MAX_OCTAVES;
  localparam int DW    = MAX_OCTAVES;
  localparam int BPS   = 4;
  localparam int NS    = (ACC_W + BPS - 1) / BPS;

  logic [DW:0]       one_sh;
  logic [DW-1:0]     rem_st [NS+1];
  logic [ACC_W-1:0]  dq_st  [NS+1];
  logic [DW-1:0]     dvs_st [NS+1];
  logic              v_st   [NS+1];

  assign one_sh    = (DW+1)'(1) << ctl_in.octaves;
  assign rem_st[0] = '0;
  assign dq_st[0]  = acc_in;
  assign dvs_st[0] = DW'(one_sh - (DW+1)'(1));
  assign v_st[0]   = ctl_in.valid;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int STEPS = ((ACC_W - s * BPS) < BPS) ? (ACC_W - s * BPS) : BPS;

    logic [DW-1:0]    rem_c;
    logic [ACC_W-1:0] dq_c;
    logic [DW-1:0]    rem_r;
    logic [ACC_W-1:0] dq_r;
    logic [DW-1:0]    dvs_r;
    logic             v_r;

    always_comb begin
      logic [DW:0] trial;
      rem_c = rem_st[s];
      dq_c  = dq_st[s];
      for (int k = 0; k < STEPS; k++) begin
        trial = {rem_c, dq_c[ACC_W-1]};
        dq_c  = dq_c << 1;
        if (trial >= {1'b0, dvs_st[s]}) begin
          rem_c    = DW'(trial - {1'b0, dvs_st[s]});
          dq_c[0]  = 1'b1;
        end else begin
          rem_c = trial[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (step_en) begin
        v_r <= v_st[s];
      end
    end

    always_ff @(posedge clk) begin
      if (step_en) begin
        rem_r <= rem_c;
        dq_r  <= dq_c;
        dvs_r <= dvs_st[s];
      end
    end

    assign rem_st[s+1] = rem_r;
    assign dq_st[s+1]  = dq_r;
    assign dvs_st[s+1] = dvs_r;
    assign v_st[s+1]   = v_r;
  end

  assign quot_valid = v_st[NS];
  assign quot       = dq_st[NS];

endmodule

// ===== rtl/core/fbm_value_noise_2d.sv =====
// fractal 2d value noise: one point in, one Q0.24 noise value out
// five stages per octave, then the divider stages and the output register
// throughput one point per cycle; a held output freezes the whole pipeline
// rst is synchronous and clears every valid bit; no clearing pass is needed
// depends on fbm_pkg, fbm_in_if, fbm_out_if, fbm_octave, fbm_div
module fbm_value_noise_2d import fbm_pkg::*; #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst,
  fbm_in_if.sink          sample,
  fbm_out_if.source       result
);

  localparam int PW    = 32 + FRAC_BITS;
  localparam int ACC_W = 24 + MAX_OCTAVES;

  // pipeline moves whenever the output register is free or being drained
  logic step_en;
  logic out_valid;
  logic [23:0] out_noise;

  assign step_en      = !out_valid || result.ready;
  assign sample.ready = step_en;

  // octave count clamped to 1..MAX_OCTAVES at entry
  logic [OCT_W-1:0] n_in;
  logic [OCT_W-1:0] n_raw;

  assign n_raw = OCT_W'(sample.octave_count);

  always_comb begin
    if (n_raw == '0) begin
      n_in = OCT_W'(1);
    end else if (n_raw > OCT_W'(MAX_OCTAVES)) begin
      n_in = OCT_W'(MAX_OCTAVES);
    end else begin
      n_in = n_raw;
    end
  end

  // octave chain, element i feeds octave i
  fbm_ctl_t             ctl_ch  [MAX_OCTAVES+1];
  logic signed [PW-1:0] px_ch   [MAX_OCTAVES+1];
  logic signed [PW-1:0] pz_ch   [MAX_OCTAVES+1];
  logic [31:0]          seed_ch [MAX_OCTAVES+1];
  logic [ACC_W-1:0]     acc_ch  [MAX_OCTAVES+1];

  // a transfer enters with the inputs sign extended to the internal format
  assign ctl_ch[0].valid   = sample.valid;
  assign ctl_ch[0].octaves = n_in;
  assign px_ch[0]          = {{FRAC_BITS{sample.pos_x[31]}}, sample.pos_x};
  assign pz_ch[0]          = {{FRAC_BITS{sample.pos_z[31]}}, sample.pos_z};
  assign seed_ch[0]        = sample.seed;
  assign acc_ch[0]         = '0;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fbm_octave #(
      .FRAC_BITS   (FRAC_BITS),
      .MAX_OCTAVES (MAX_OCTAVES),
      .OCT_IDX     (i)
    ) u_octave (
      .clk      (clk),
      .rst      (rst),
      .step_en  (step_en),
      .ctl_in   (ctl_ch[i]),
      .px_in    (px_ch[i]),
      .pz_in    (pz_ch[i]),
      .seed_in  (seed_ch[i]),
      .acc_in   (acc_ch[i]),
      .ctl_out  (ctl_ch[i+1]),
      .px_out   (px_ch[i+1]),
      .pz_out   (pz_ch[i+1]),
      .seed_out (seed_ch[i+1]),
      .acc_out  (acc_ch[i+1])
    );
  end

  // normalize by the total weight 2^n - 1
  logic             quot_valid;
  logic [ACC_W-1:0] quot;

  fbm_div #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .step_en    (step_en),
    .ctl_in     (ctl_ch[MAX_OCTAVES]),
    .acc_in     (acc_ch[MAX_OCTAVES]),
    .quot_valid (quot_valid),
    .quot       (quot)
  );

  // output register with saturation to Q0.24
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= quot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_noise <= (|quot[ACC_W-1:24]) ? Q24_MAX : quot[23:0];
    end
  end

  assign result.valid       = out_valid;
  assign result.noise_value = out_noise;

endmodule

// ===== rtl/core/fbm_chk.sv =====
// port level checks for fbm_value_noise_2d, attached by bind
// depends on fbm_value_noise_2d
module fbm_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] noise_value
);

  // a result that is not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // and keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(noise_value))
    else $error("result changed while stalled");

  // input side stalls exactly when a result is held back
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind fbm_value_noise_2d fbm_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .noise_value (result.noise_value)
);
